// ----- rtl/lete_pkg.sv -----
// Shared types and constants of the line editor text grid.
`default_nettype none
package lete_pkg;
	localparam logic [7:0] KeyEsc = 8'h1B;
	localparam logic [7:0] KeyCr = 8'h0D;
	localparam logic [7:0] KeyDel = 8'd127;
	localparam logic [7:0] KeyLbr = 8'h5B;
	localparam logic [7:0] KeyColon = 8'h3A;
	localparam logic [7:0] KeyA = 8'h41;
	localparam logic [7:0] KeyB = 8'h42;
	localparam logic [7:0] KeyC = 8'h43;
	localparam logic [7:0] KeyD = 8'h44;
	localparam logic [7:0] KeyQ = 8'h71;
	localparam logic [7:0] KeyW = 8'h77;
	localparam logic [7:0] PrintLo = 8'd32;
	localparam logic [7:0] PrintHi = 8'd126;
	localparam logic RegRows = 1'b0;
	localparam logic RegCols = 1'b1;
	localparam logic [1:0] EvNone = 2'd0;
	localparam logic [1:0] EvExit = 2'd1;
	localparam logic [1:0] EvSave = 2'd2;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_CLEAR, CMD_DECODE, CMD_READ, CMD_RDCELL, CMD_SHIFT_R,
		CMD_SHIFT_L, CMD_PUT, CMD_DONE
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} ctl_t;

	typedef struct packed {
		logic clear_done;
		logic do_ins;
		logic do_del;
		logic shift_done;
	} sts_t;
endpackage
`default_nettype wire

// ----- rtl/lete_datapath.sv -----
// Datapath of the line editor: cursor, lengths, character memory and decode.
`default_nettype none
module lete_datapath import lete_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLUMNS = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_idx,
	input wire logic [7:0] cfg_data,
	input wire logic operation,
	input wire logic [7:0] key_byte,
	input wire logic [5:0] read_row,
	input wire logic [6:0] read_column,
	input wire ctl_t ctl,
	output sts_t sts,
	output logic [5:0] cursor_row,
	output logic [6:0] cursor_column,
	output logic [6:0] row_length,
	output logic [6:0] cell_value,
	output logic [1:0] event_res
);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int AW = RW + CW;
	localparam logic [1:0] PhIdle = 2'd0;
	localparam logic [1:0] PhEsc = 2'd1;
	localparam logic [1:0] PhFirst = 2'd2;

	logic [RW-1:0] y_q;
	logic [CW:0] x_q;
	logic [CW:0] len_q;
	logic [CW:0] len_mem [MAX_ROWS];
	logic [CW:0] nlen_up_q, nlen_dn_q;
	logic [6:0] mem [2**AW];
	logic [6:0] rd_q;
	logic [AW-1:0] clr_q;
	logic [CW:0] i_q;
	logic [1:0] phase_q;
	logic [7:0] first_q;
	logic [6:0] rows_q;
	logic [7:0] cols_q;
	logic [7:0] key_q;
	logic op_q;
	logic [5:0] rr_q;
	logic [6:0] rc_q;
	logic ins_go_q, del_go_q;

	logic [8:0] erows, ecols;
	logic [CW:0] i_nx;
	logic ins_ok, del_ok, rd_in;
	logic [AW-1:0] raddr;
	logic we;
	logic [AW-1:0] waddr;
	logic [6:0] wdata;

	always_comb begin
		erows = (rows_q == 7'd0) ? 9'd1 : ((9'(rows_q) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS)
			: 9'(rows_q));
		ecols = (cols_q < 8'd2) ? 9'd2 : ((9'(cols_q) > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS)
			: 9'(cols_q));
		ins_ok = (9'(len_q) + 9'd1 < ecols) && (9'(x_q) < ecols);
		del_ok = (x_q != '0) && (x_q <= len_q);
		rd_in = (32'(rr_q) < MAX_ROWS) && (32'(rc_q) < MAX_COLUMNS);
		raddr = {RW'(rr_q), CW'(rc_q)};
		we = 1'b0;
		waddr = {y_q, CW'(i_q)};
		wdata = '0;
		case (ctl.cmd)
			CMD_CLEAR: begin we = 1'b1; waddr = clr_q; end
			CMD_READ: raddr = {RW'(read_row), CW'(read_column)};
			CMD_RDCELL: raddr = op_q ? {y_q, CW'(i_q - 1'b1)} : {y_q, CW'(i_q + 1'b1)};
			CMD_PUT: begin we = 1'b1; waddr = {y_q, CW'(x_q)}; wdata = key_q[6:0]; end
			default: ;
		endcase
		// The loop ends once the index about to be moved is outside the shift range.
		i_nx = (ctl.cmd == CMD_SHIFT_R) ? i_q - 1'b1
			: ((ctl.cmd == CMD_SHIFT_L) ? i_q + 1'b1 : i_q);
		sts.clear_done = (clr_q == '1);
		sts.do_ins = ins_go_q;
		sts.do_del = del_go_q;
		sts.shift_done = op_q ? (i_nx <= x_q) : (9'(i_nx) + 9'd1 >= 9'(len_q));
	end

	// Shift loop: CMD_RDCELL reads the neighbour, CMD_SHIFT_* writes it.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (ctl.cmd == CMD_SHIFT_R || ctl.cmd == CMD_SHIFT_L)
			mem[{y_q, CW'(i_q)}] <= rd_q;
		rd_q <= mem[raddr];
		case (ctl.cmd)
			CMD_CLEAR: len_mem[clr_q[AW-1:CW]] <= '0;
			CMD_PUT: len_mem[y_q] <= len_q + 1'b1;
			CMD_DONE: len_mem[y_q] <= len_q - 1'b1;
			default: ;
		endcase
		// Lengths of the rows above and below, ready for the next arrow move.
		nlen_up_q <= len_mem[y_q - RW'(1)];
		nlen_dn_q <= len_mem[y_q + RW'(1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q <= '0; x_q <= '0; clr_q <= '0; i_q <= '0; phase_q <= PhIdle;
			first_q <= '0; rows_q <= 7'd24; cols_q <= 8'd80; event_res <= EvNone;
			cell_value <= '0; op_q <= 1'b0; key_q <= '0; rr_q <= '0; rc_q <= '0;
			len_q <= '0; ins_go_q <= 1'b0; del_go_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == RegRows) rows_q <= cfg_data[6:0];
				else cols_q <= cfg_data;
			end
			case (ctl.cmd)
				CMD_CLEAR: clr_q <= clr_q + 1'b1;
				CMD_READ: begin
					op_q <= operation; key_q <= key_byte; rr_q <= read_row;
					rc_q <= read_column; event_res <= EvNone; cell_value <= '0;
					ins_go_q <= 1'b0; del_go_q <= 1'b0;
				end
				CMD_DECODE: begin
					if (op_q) begin
						cell_value <= rd_in ? rd_q : 7'd0;
					end else if (phase_q == PhEsc) begin
						first_q <= key_q; phase_q <= PhFirst;
					end else if (phase_q == PhFirst) begin
						phase_q <= PhIdle;
						if (first_q == KeyLbr) begin
							if (key_q == KeyA && y_q != '0) begin
								y_q <= y_q - 1'b1;
								len_q <= nlen_up_q;
								if (x_q > nlen_up_q) x_q <= nlen_up_q;
							end else if (key_q == KeyB && 9'(y_q) + 9'd1 < erows) begin
								y_q <= y_q + 1'b1;
								len_q <= nlen_dn_q;
								if (x_q > nlen_dn_q) x_q <= nlen_dn_q;
							end else if (key_q == KeyC && 9'(x_q) + 9'd1 < ecols) begin
								x_q <= x_q + 1'b1;
							end else if (key_q == KeyD && x_q != '0) begin
								x_q <= x_q - 1'b1;
							end
						end else if (first_q == KeyColon) begin
							if (key_q == KeyQ) event_res <= EvExit;
							else if (key_q == KeyW) event_res <= EvSave;
						end
					end else if (key_q == KeyEsc) begin
						phase_q <= PhEsc;
					end else if (key_q == KeyDel) begin
						if (x_q != '0 && !del_ok) x_q <= x_q - 1'b1;
						// Shift left starts at x-1; direction flag reuses op_q.
						op_q <= 1'b0; i_q <= x_q - 1'b1; del_go_q <= del_ok;
					end else if (key_q == KeyCr) begin
						x_q <= '0;
					end else begin
						op_q <= 1'b1; i_q <= len_q;
						ins_go_q <= (key_q >= PrintLo) && (key_q <= PrintHi) && ins_ok;
					end
				end
				CMD_SHIFT_R: i_q <= i_q - 1'b1;
				CMD_SHIFT_L: i_q <= i_q + 1'b1;
				CMD_PUT: begin
					len_q <= len_q + 1'b1;
					if (9'(x_q) + 9'd1 < ecols) x_q <= x_q + 1'b1;
				end
				CMD_DONE: begin
					len_q <= len_q - 1'b1;
					x_q <= x_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign cursor_row = 6'(y_q);
	assign cursor_column = 7'(x_q);
	assign row_length = 7'(len_q);
endmodule
`default_nettype wire

// ----- rtl/lete_ctrl.sv -----
// Controller of the line editor: clearing pass, decode and shift sequencing.
`default_nettype none
module lete_ctrl import lete_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic operation,
	input wire logic [7:0] key_byte,
	input wire sts_t sts,
	output ctl_t ctl,
	output logic busy,
	output logic done
);
	typedef enum logic [2:0] {S_CLR, S_IDLE, S_DEC, S_CHK, S_RD, S_WR, S_PUT, S_FIN}
		state_t;
	state_t st_q;
	logic ins_q, del_q;

	always_comb begin
		case (st_q)
			S_CLR: ctl.cmd = CMD_CLEAR;
			S_IDLE: ctl.cmd = start ? CMD_READ : CMD_NONE;
			S_DEC: ctl.cmd = CMD_DECODE;
			S_RD: ctl.cmd = CMD_RDCELL;
			S_WR: ctl.cmd = ins_q ? CMD_SHIFT_R : CMD_SHIFT_L;
			S_PUT: ctl.cmd = CMD_PUT;
			S_FIN: ctl.cmd = del_q ? CMD_DONE : CMD_NONE;
			default: ctl.cmd = CMD_NONE;
		endcase
		busy = (st_q != S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; ins_q <= 1'b0; del_q <= 1'b0; done <= 1'b0;
		end else begin
			done <= (st_q == S_FIN);
			case (st_q)
				S_CLR: if (sts.clear_done) st_q <= S_IDLE;
				S_IDLE: if (start) begin
					st_q <= S_DEC;
					ins_q <= !operation && key_byte >= PrintLo && key_byte <= PrintHi;
					del_q <= !operation && key_byte == KeyDel;
				end
				S_DEC: st_q <= S_CHK;
				S_CHK: begin
					// The decode step has left the edit flags and the shift start behind.
					if (ins_q && sts.do_ins) st_q <= sts.shift_done ? S_PUT : S_RD;
					else if (del_q && sts.do_del) st_q <= sts.shift_done ? S_FIN : S_RD;
					else begin ins_q <= 1'b0; del_q <= 1'b0; st_q <= S_FIN; end
				end
				S_RD: st_q <= S_WR;
				S_WR: st_q <= sts.shift_done ? (ins_q ? S_PUT : S_FIN) : S_RD;
				S_PUT: st_q <= S_FIN;
				S_FIN: begin st_q <= S_IDLE; ins_q <= 1'b0; del_q <= 1'b0; end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && start) |=> busy) else $error("start not taken");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == S_IDLE) else $error("done outside idle");
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double done");
endmodule
`default_nettype wire

// ----- rtl/line_editor_text_grid_unit.sv -----
// Top level of the line editor text grid unit.
`default_nettype none
// After reset the unit clears its character memory and its row lengths, one
// cell a cycle, holding busy high. An item is taken when start is high and
// busy low; its one result beat appears with done for a single cycle and
// cannot be stalled. Reads, cursor moves and ignored keys pass through the
// decode, check and finish states; an insert or a delete moves each shifted
// character one at a time, read in S_RD and written in S_WR, and an insert
// then writes the new character in S_PUT, while a delete ends in S_FIN.
// The next item may be taken at the edge that ends the result beat.
module line_editor_text_grid_unit import lete_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLUMNS = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_idx,
	input wire logic [7:0] cfg_data,
	input wire logic start,
	output logic busy,
	output logic done,
	input wire logic operation,
	input wire logic [7:0] key_byte,
	input wire logic [5:0] read_row,
	input wire logic [6:0] read_column,
	output logic [5:0] cursor_row,
	output logic [6:0] cursor_column,
	output logic [6:0] row_length,
	output logic [6:0] cell_value,
	output logic [1:0] event_res
);
	ctl_t ctl;
	sts_t sts;

	lete_ctrl u_ctrl (.clk, .arst_n, .start, .operation, .key_byte, .sts, .ctl, .busy,
		.done);
	lete_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_dp (.clk, .arst_n,
		.cfg_we, .cfg_idx, .cfg_data, .operation, .key_byte, .read_row, .read_column,
		.ctl, .sts, .cursor_row, .cursor_column, .row_length, .cell_value, .event_res);
endmodule
`default_nettype wire
